// ===== rtl/stxr_pkg.sv =====
// Package for the scaled text rasterizer: types, constants and the 5x7 font.
// Used by every module of the block; depends on nothing.
`default_nettype none

package stxr_pkg;

    // Geometry and limits
    localparam int MAX_SCALE     = 63;
    localparam int SURFACE_LIMIT = 4096;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_BITS    = GLYPH_COLS * GLYPH_ROWS;
    localparam int ADVANCE_CELLS = 6;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef logic [0:0] reg_index_t;
    localparam reg_index_t REG_SURFACE_WIDTH  = 1'b0;
    localparam reg_index_t REG_SURFACE_HEIGHT = 1'b1;

    // Character codes with special handling
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Clamped surface size, shared by front and back
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
    } surface_t;

    // One character worth of drawing work; mask bit (row*5 + col) is a square to emit
    typedef struct packed {
        logic [16:0]           x;
        logic [15:0]           y;
        logic [5:0]            scale;
        logic [7:0]            color;
        logic [GLYPH_BITS-1:0] mask;
    } job_t;

    // Output word payload, x in the low bits
    typedef struct packed {
        logic [7:0]  color;
        logic [5:0]  height;
        logic [5:0]  width;
        logic [11:0] y;
        logic [11:0] x;
    } rect_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

    // Glyph rows, row 0 in the top five bits, bit 4 of a row is the left column
    function automatic logic [GLYPH_BITS-1:0] glyph_rows(input logic [7:0] code);
        logic [7:0]            folded;
        logic [GLYPH_BITS-1:0] rows;
        if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            folded = code - CASE_OFFSET;
        end else begin
            folded = code;
        end
        unique case (folded)
            8'h30: rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34: rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36: rows = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            8'h41: rows = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43: rows = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            8'h44: rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            8'h45: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47: rows = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            8'h48: rows = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49: rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h4A: rows = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
            8'h4B: rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: rows = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h51: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            8'h52: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: rows = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56: rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            8'h57: rows = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h58: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59: rows = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5A: rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            8'h2E: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            8'h2C: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h04, 5'h08};
            8'h3A: rows = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
            8'h3B: rows = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h04, 5'h08};
            8'h2D: rows = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            8'h5F: rows = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            8'h2B: rows = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            8'h3D: rows = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
            8'h2F: rows = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
            8'h5C: rows = {5'h10, 5'h08, 5'h08, 5'h04, 5'h02, 5'h02, 5'h01};
            8'h28: rows = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
            8'h29: rows = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
            8'h5B: rows = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
            8'h5D: rows = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
            8'h3C: rows = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
            8'h3E: rows = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
            8'h21: rows = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            8'h3F: rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            8'h23: rows = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
            8'h2A: rows = {5'h00, 5'h0A, 5'h04, 5'h1F, 5'h04, 5'h0A, 5'h00};
            8'h40: rows = {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
            8'h25: rows = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
            8'h26: rows = {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D};
            8'h7C: rows = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h27: rows = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
            8'h22: rows = {5'h0A, 5'h0A, 5'h14, 5'h00, 5'h00, 5'h00, 5'h00};
            CHAR_SPACE: rows = '0;
            // anything outside the font draws a hollow box
            default: rows = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
        endcase
        return rows;
    endfunction

    // Reorder the glyph into scan order: bit (row*5 + col), col 0 at the left
    function automatic logic [GLYPH_BITS-1:0] glyph_mask(input logic [7:0] code);
        logic [GLYPH_BITS-1:0] rows;
        logic [GLYPH_BITS-1:0] mask;
        rows = glyph_rows(code);
        mask = '0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                mask[r * GLYPH_COLS + c] =
                    rows[(GLYPH_ROWS - 1 - r) * GLYPH_COLS + (GLYPH_COLS - 1 - c)];
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stxr_front.sv =====
// Front end: takes characters, tracks the string cursor and builds clipped glyph masks.
// Depends on stxr_pkg; feeds jobs into stxr_queue.
`default_nettype none

module stxr_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [55:0]           s_tdata,   // start_x, start_y, scale, color, character
    input  wire  [0:0]            s_tuser,   // first
    input  stxr_pkg::surface_t    surface,
    input  wire                   q_ready,
    output logic                  q_push,
    output stxr_pkg::job_t        q_job
);
    import stxr_pkg::*;

    logic [16:0] cursor_reg, cursor_next;
    logic [15:0] line_y_reg, line_y_next;
    logic [5:0]  scale_reg, scale_next;
    logic [7:0]  color_reg, color_next;
    logic        stopped_reg, stopped_next;

    logic [15:0] in_start_x, in_start_y;
    logic [5:0]  in_scale, sat_scale;
    logic [7:0]  in_color, in_char;
    logic        accept;

    logic [16:0] cx_eff, cursor_adv;
    logic [15:0] ly_eff;
    logic [5:0]  s_eff;
    logic [7:0]  c_eff;
    logic        stop_eff;

    logic [GLYPH_COLS-1:0] col_vis;
    logic [GLYPH_ROWS-1:0] row_vis;
    logic [GLYPH_BITS-1:0] vis_mask, draw_mask;

    // Input word unpacking
    assign in_start_x = s_tdata[15:0];
    assign in_start_y = s_tdata[31:16];
    assign in_scale   = s_tdata[37:32];
    assign in_color   = s_tdata[45:38];
    assign in_char    = s_tdata[53:46];
    assign sat_scale  = (in_scale > 6'(MAX_SCALE)) ? 6'(MAX_SCALE) : in_scale;

    assign s_tready = q_ready;
    assign accept   = s_tvalid & s_tready;

    // String state seen by this character
    always_comb begin
        if (s_tuser[0]) begin
            cx_eff   = {1'b0, in_start_x};
            ly_eff   = in_start_y;
            s_eff    = sat_scale;
            c_eff    = in_color;
            stop_eff = (sat_scale == '0);
        end else begin
            cx_eff   = cursor_reg;
            ly_eff   = line_y_reg;
            s_eff    = scale_reg;
            c_eff    = color_reg;
            stop_eff = stopped_reg;
        end
    end

    // Visible columns and rows form prefixes; build the clip mask from them
    always_comb begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
            col_vis[c] = (18'(cx_eff) + 18'(s_eff) * 18'(c)) < 18'(surface.width);
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            row_vis[r] = (17'(ly_eff) + 17'(s_eff) * 17'(r)) < 17'(surface.height);
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                vis_mask[r * GLYPH_COLS + c] = row_vis[r] & col_vis[c];
            end
        end
    end

    assign draw_mask  = glyph_mask(in_char) & vis_mask;
    assign cursor_adv = cx_eff + 17'(s_eff) * 17'(ADVANCE_CELLS);

    // Only characters with at least one square go to the back end
    assign q_push      = accept & ~stop_eff & (|draw_mask);
    assign q_job.x     = cx_eff;
    assign q_job.y     = ly_eff;
    assign q_job.scale = s_eff;
    assign q_job.color = c_eff;
    assign q_job.mask  = draw_mask;

    // Cursor advance and stop decision
    always_comb begin
        cursor_next  = cursor_reg;
        line_y_next  = line_y_reg;
        scale_next   = scale_reg;
        color_next   = color_reg;
        stopped_next = stopped_reg;
        if (accept) begin
            line_y_next = ly_eff;
            scale_next  = s_eff;
            color_next  = c_eff;
            if (stop_eff) begin
                cursor_next  = cx_eff;
                stopped_next = 1'b1;
            end else begin
                cursor_next  = cursor_adv;
                stopped_next = (cursor_adv >= 17'(surface.width));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            line_y_reg  <= '0;
            scale_reg   <= '0;
            color_reg   <= '0;
            stopped_reg <= 1'b1;
        end else begin
            cursor_reg  <= cursor_next;
            line_y_reg  <= line_y_next;
            scale_reg   <= scale_next;
            color_reg   <= color_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stxr_queue.sv =====
// Short job queue between the front end and the square generator.
// Depends on stxr_pkg for the job type and depth.
`default_nettype none

module stxr_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  stxr_pkg::job_t     push_job,
    output logic               ready,
    input  wire                pop,
    output logic               valid,
    output stxr_pkg::job_t     pop_job
);
    import stxr_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push & ready;
    assign do_pop  = pop & valid;

    // Pointer and fill level
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stxr_back.sv =====
// Square generator: walks a job's glyph mask and emits one trimmed square per set bit.
// Depends on stxr_pkg; takes jobs from stxr_queue and drives the result channel.
`default_nettype none

module stxr_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  stxr_pkg::surface_t  surface,
    input  wire                 q_valid,
    input  stxr_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [47:0]         m_tdata,   // rect_x, rect_y, rect_width, rect_height,
                                           // fill_color
    output logic                m_tlast    // last
);
    import stxr_pkg::*;

    back_state_t           state_reg, state_next;
    logic [16:0]           base_x_reg, base_x_next;
    logic [17:0]           x_acc_reg, x_acc_next;
    logic [16:0]           y_acc_reg, y_acc_next;
    logic [5:0]            scale_reg, scale_next;
    logic [7:0]            color_reg, color_next;
    logic [GLYPH_BITS-1:0] mask_reg, mask_next;
    logic [2:0]            col_reg, col_next;

    rect_t                 out_reg, out_next;
    logic                  last_reg, last_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  out_free, cur_bit, step;
    logic [12:0]           room_x, room_y;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg};
    assign m_tlast  = last_reg;

    assign out_free = ~m_tvalid_reg | m_tready;
    assign cur_bit  = mask_reg[0];
    assign step     = (state_reg == BK_SCAN) && (!cur_bit || out_free);
    assign q_pop    = (state_reg == BK_IDLE) && q_valid;

    // Space left to the right and bottom edges; only read for visible squares
    assign room_x = surface.width - x_acc_reg[12:0];
    assign room_y = surface.height - y_acc_reg[12:0];

    // Scan one glyph position per cycle, stall while a square waits on the output
    always_comb begin
        state_next    = state_reg;
        base_x_next   = base_x_reg;
        x_acc_next    = x_acc_reg;
        y_acc_next    = y_acc_reg;
        scale_next    = scale_reg;
        color_next    = color_reg;
        mask_next     = mask_reg;
        col_next      = col_reg;
        out_next      = out_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    base_x_next = q_job.x;
                    x_acc_next  = 18'(q_job.x);
                    y_acc_next  = 17'(q_job.y);
                    scale_next  = q_job.scale;
                    color_next  = q_job.color;
                    mask_next   = q_job.mask;
                    col_next    = '0;
                    state_next  = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (step) begin
                    if (cur_bit) begin
                        out_next.x      = x_acc_reg[11:0];
                        out_next.y      = y_acc_reg[11:0];
                        out_next.width  = (room_x < 13'(scale_reg)) ? room_x[5:0] : scale_reg;
                        out_next.height = (room_y < 13'(scale_reg)) ? room_y[5:0] : scale_reg;
                        out_next.color  = color_reg;
                        last_next       = (mask_reg[GLYPH_BITS-1:1] == '0);
                        m_tvalid_next   = 1'b1;
                    end
                    mask_next = {1'b0, mask_reg[GLYPH_BITS-1:1]};
                    if (col_reg == 3'(GLYPH_COLS - 1)) begin
                        col_next   = '0;
                        x_acc_next = 18'(base_x_reg);
                        y_acc_next = y_acc_reg + 17'(scale_reg);
                    end else begin
                        col_next   = col_reg + 1'b1;
                        x_acc_next = x_acc_reg + 18'(scale_reg);
                    end
                    if (mask_reg[GLYPH_BITS-1:1] == '0) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Job and output payload
    always_ff @(posedge aclk) begin
        base_x_reg <= base_x_next;
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        scale_reg  <= scale_next;
        color_reg  <= color_next;
        mask_reg   <= mask_next;
        col_reg    <= col_next;
        out_reg    <= out_next;
        last_reg   <= last_next;
    end

`ifndef SYNTHESIS
    // A scan never runs on an empty mask
    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SCAN |-> mask_reg != '0)
        else $error("scan active with empty mask");

    // Emitted squares are never empty
    a_nonzero_square: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_reg.width != '0) && (out_reg.height != '0))
        else $error("zero sized square emitted");

    // Emitted squares start inside the surface
    a_inside_surface: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (13'(out_reg.x) < surface.width) && (13'(out_reg.y) < surface.height))
        else $error("square starts outside the surface");

    // A job is only taken while the scanner is idle, and taking one starts a scan
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == BK_SCAN)
        else $error("job taken without starting a scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/scaled_text_rasterizer.sv =====
// Scaled text rasterizer, 5x7 font: each character in becomes up to 35 clipped squares out.
// A character passes through the front end and is queued (two deep); the square generator
// then loads it from its idle state and scans one glyph position per cycle, stalling while
// a square waits on the output, up to its last visible lit pixel. Characters that draw
// nothing (space, stopped string, fully clipped) are dropped by the front end and never
// queued. Squares of one character arrive in row order, left to right, with tlast on the
// final one. Surface width and height are written over the configuration channel (index 0
// and 1); the user must do so only while the block is idle, which the block does not enforce.
// Values above 4096 act as 4096. Depends on stxr_pkg, stxr_front, stxr_queue and stxr_back.
`default_nettype none

module scaled_text_rasterizer (
    input  wire                        aclk,
    input  wire                        aresetn,
    // character input
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [55:0]                s_tdata,   // start_x, start_y, scale, color, character
    input  wire  [0:0]                 s_tuser,   // first
    // square output
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [47:0]                m_tdata,   // rect_x, rect_y, rect_width, rect_height,
                                                  // fill_color
    output logic                       m_tlast,   // last
    // configuration writes
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire  [0:0]                 cfg_index,
    input  wire  [12:0]                cfg_data
);
    import stxr_pkg::*;

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    surface_t    surface;
    logic        q_push, q_ready, q_pop, q_valid;
    job_t        push_job, pop_job;

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SURFACE_WIDTH:  width_next  = cfg_data;
                REG_SURFACE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Clamp to the largest supported surface
    assign surface.width  = (width_reg > 13'(SURFACE_LIMIT)) ? 13'(SURFACE_LIMIT) : width_reg;
    assign surface.height = (height_reg > 13'(SURFACE_LIMIT)) ? 13'(SURFACE_LIMIT) : height_reg;

    stxr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .surface  (surface),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    stxr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    stxr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .surface  (surface),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
